// ===== design/sh9_pkg.sv =====
// Shared types, constants and tables for the SH9 irradiance accumulator.
// Used by the front queue, the back datapath, the top level and the checker.
package sh9_pkg;

  localparam int unsigned ACC_WIDTH_DEF = 64;
  localparam int unsigned NUM_SUMS      = 27;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned BAND_W        = 4;
  localparam int unsigned CH_W          = 2;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned GAIN_W        = 32;
  localparam int unsigned FIFO_DEPTH    = 4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SUMS - 1);

  // Basis terms in band order
  localparam logic [BAND_W-1:0] BAND_ONE  = 4'd0;
  localparam logic [BAND_W-1:0] BAND_Y    = 4'd1;
  localparam logic [BAND_W-1:0] BAND_Z    = 4'd2;
  localparam logic [BAND_W-1:0] BAND_X    = 4'd3;
  localparam logic [BAND_W-1:0] BAND_XY   = 4'd4;
  localparam logic [BAND_W-1:0] BAND_YZ   = 4'd5;
  localparam logic [BAND_W-1:0] BAND_ZZ   = 4'd6;
  localparam logic [BAND_W-1:0] BAND_ZX   = 4'd7;
  localparam logic [BAND_W-1:0] BAND_XXYY = 4'd8;
  localparam logic [BAND_W-1:0] BAND_LAST = BAND_XXYY;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } sh9_kind_e;

  typedef struct packed {
    sh9_kind_e   kind;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [23:0] weight;
  } sh9_item_t;

  // Cosine-lobe gains, Q0.32
  function automatic logic [GAIN_W-1:0] band_gain(input logic [BAND_W-1:0] band);
    logic [GAIN_W-1:0] k;
    unique case (band)
      BAND_ONE:                   k = 32'd341782638;
      BAND_Y, BAND_Z, BAND_X:     k = 32'd683565276;
      BAND_XY, BAND_YZ, BAND_ZX:  k = 32'd1281684892;
      BAND_ZZ:                    k = 32'd106807074;
      BAND_XXYY:                  k = 32'd320421223;
      default:                    k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== design/sh9_if.sv =====
// Valid/ready channel interfaces for the SH9 accumulator: sample/command in,
// coefficient out. No dependencies.
interface sh9_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic        [15:0] red;
  logic        [15:0] green;
  logic        [15:0] blue;
  logic        [23:0] weight;

  modport source (
    output valid, cmd, dir_x, dir_y, dir_z, red, green, blue, weight,
    input  ready
  );
  modport sink (
    input  valid, cmd, dir_x, dir_y, dir_z, red, green, blue, weight,
    output ready
  );
endinterface

interface sh9_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coefficient;
  logic        [3:0]  band;
  logic        [1:0]  channel;
  logic               last;

  modport source (
    output valid, coefficient, band, channel, last,
    input  ready
  );
  modport sink (
    input  valid, coefficient, band, channel, last,
    output ready
  );
endinterface

// ===== design/sh9_irradiance_accumulator_core.sv =====
// Readout: the first coefficient passes the front queue, the sequencer and
// stages p1, p2, p3, r1, r2 and out; then one coefficient per cycle (27 in all)
// unless the sink stalls. The back-end sequencer walks the 27 accumulator slots
// of each request (add or readout) through one multiply chain and takes a new request only with the last slot.
// Input takes up to 4 requests ahead in the front queue.
// Reset: asynchronous, active low; clears the accumulators, queue and pipeline.
module sh9_irradiance_accumulator_core import sh9_pkg::*; #(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sh9_in_if.sink     in_i,
  sh9_out_if.source  out_o
);

  logic      q_valid;
  logic      q_ready;
  sh9_item_t q_item;

  sh9_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  sh9_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .out_o     (out_o)
  );

endmodule

// ===== design/sh9_front.sv =====
// Front end: accepts requests, classifies them as add or readout and queues
// them for the back end. Depends on sh9_pkg and sh9_in_if.
module sh9_front import sh9_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sh9_in_if.sink    in_i,
  output logic      q_valid_o,
  output sh9_item_t q_item_o,
  input  logic      q_ready_i
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  sh9_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             push, pop;
  sh9_item_t        item_in;

  assign in_i.ready = (count_q != (PTR_W + 1)'(FIFO_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    item_in.kind   = in_i.cmd ? KIND_READ : KIND_ADD;
    item_in.dir_x  = in_i.dir_x;
    item_in.dir_y  = in_i.dir_y;
    item_in.dir_z  = in_i.dir_z;
    item_in.red    = in_i.red;
    item_in.green  = in_i.green;
    item_in.blue   = in_i.blue;
    item_in.weight = in_i.weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_in;
  end

endmodule

// ===== design/sh9_back.sv =====
// Back end: walks the 27 accumulator slots for each queued request, through
// basis, weight, colour and accumulate stages, or the readout scaling stages.
// Depends on sh9_pkg and sh9_out_if.
module sh9_back import sh9_pkg::*; #(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  sh9_item_t  q_item_i,
  output logic       q_ready_o,
  sh9_out_if.source  out_o
);

  localparam int unsigned BASIS_W = 33;
  localparam int unsigned WPROD_W = 58;
  localparam int unsigned F_W     = 27;
  localparam int unsigned INC_W   = 44;
  localparam int unsigned SUM_W   = ACC_WIDTH + 1;
  localparam int unsigned EXT_W   = 65;
  localparam int unsigned MAG_W   = 57;
  localparam int unsigned PL_W    = 64;
  localparam int unsigned T_W     = 58;
  localparam int unsigned Q_W     = 42;

  localparam logic signed [17:0]          UNIT_Q15 = 18'sd32768;
  localparam logic signed [BASIS_W-1:0]   ONE_Q30  = BASIS_W'(1 << 30);
  localparam logic signed [WPROD_W-1:0]   HALF_Q30 = WPROD_W'(1 << 29);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX  = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN  = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
  localparam logic [EXT_W-1:0]            MAG_CAP  = EXT_W'(1) << 56;
  localparam logic [EXT_W-1:0]            RND_Q48  = EXT_W'(1) << 47;
  localparam logic [Q_W-1:0]              POS_LIM  = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0]              NEG_LIM  = Q_W'(32'h8000_0000);

  typedef struct packed {
    sh9_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [BAND_W-1:0] band;
    logic [CH_W-1:0]   ch;
  } sh9_tag_t;

  logic adv;
  logic out_vld_q;

  // Whole pipeline moves together; stall only when the output is held
  assign adv = !out_vld_q || out_o.ready;

  // ---------------- sequencer ----------------
  logic              busy_q;
  sh9_item_t         item_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BAND_W-1:0] band_q;
  logic [CH_W-1:0]   ch_q;
  logic              issue, seq_last, pop;

  assign issue     = busy_q && adv;
  assign seq_last  = (idx_q == IDX_LAST);
  assign q_ready_o = !busy_q || (issue && seq_last);
  assign pop       = q_valid_i && q_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      band_q <= '0;
      ch_q   <= CH_RED;
    end else begin
      if (issue) begin
        if (seq_last) begin
          idx_q  <= '0;
          band_q <= '0;
          ch_q   <= CH_RED;
        end else begin
          idx_q <= idx_q + 1'b1;
          if (ch_q == CH_BLUE) begin
            ch_q   <= CH_RED;
            band_q <= band_q + 1'b1;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
      end
      if (pop)                    busy_q <= 1'b1;
      else if (issue && seq_last) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) item_q <= q_item_i;
  end

  // ---------------- issue: basis term and colour select ----------------
  logic signed [15:0]        x, y, z;
  logic signed [17:0]        op_a, op_b;
  logic signed [35:0]        prod;
  logic                      is_zz;
  logic signed [BASIS_W-1:0] basis;
  logic [15:0]               col;
  sh9_tag_t                  tag_in;

  assign x = $signed(item_q.dir_x);
  assign y = $signed(item_q.dir_y);
  assign z = $signed(item_q.dir_z);

  always_comb begin
    op_a  = UNIT_Q15;
    op_b  = UNIT_Q15;
    is_zz = 1'b0;
    unique case (band_q)
      BAND_ONE: op_a = UNIT_Q15;
      BAND_Y:   op_a = 18'(y);
      BAND_Z:   op_a = 18'(z);
      BAND_X:   op_a = 18'(x);
      BAND_XY: begin
        op_a = 18'(x);
        op_b = 18'(y);
      end
      BAND_YZ: begin
        op_a = 18'(y);
        op_b = 18'(z);
      end
      BAND_ZZ: begin
        op_a  = 18'(z);
        op_b  = 18'(z) + (18'(z) <<< 1);
        is_zz = 1'b1;
      end
      BAND_ZX: begin
        op_a = 18'(z);
        op_b = 18'(x);
      end
      BAND_XXYY: begin
        // x*x - y*y as (x - y) * (x + y)
        op_a = 18'(x) - 18'(y);
        op_b = 18'(x) + 18'(y);
      end
      default: op_a = UNIT_Q15;
    endcase
    prod  = op_a * op_b;
    basis = BASIS_W'(prod) - (is_zz ? ONE_Q30 : '0);
  end

  always_comb begin
    unique case (ch_q)
      CH_RED:   col = item_q.red;
      CH_GREEN: col = item_q.green;
      default:  col = item_q.blue;
    endcase
  end

  always_comb begin
    tag_in.kind = item_q.kind;
    tag_in.idx  = idx_q;
    tag_in.band = band_q;
    tag_in.ch   = ch_q;
  end

  // ---------------- stage 1: basis registered ----------------
  logic                      p1_vld_q;
  sh9_tag_t                  p1_tag_q;
  logic signed [BASIS_W-1:0] p1_basis_q;
  logic [23:0]               p1_w_q;
  logic [15:0]               p1_col_q;

  // ---------------- stage 2: weighted term f ----------------
  logic signed [WPROD_W-1:0] wprod, wrnd;
  logic                      p2_vld_q;
  sh9_tag_t                  p2_tag_q;
  logic signed [F_W-1:0]     p2_f_q;
  logic [15:0]               p2_col_q;

  assign wprod = WPROD_W'(p1_basis_q) * $signed({1'b0, p1_w_q});
  assign wrnd  = wprod + HALF_Q30;

  // ---------------- stage 3: colour increment ----------------
  logic signed [INC_W-1:0]   inc;
  logic                      p3_vld_q;
  sh9_tag_t                  p3_tag_q;
  logic signed [INC_W-1:0]   p3_inc_q;

  assign inc = p2_f_q * $signed({1'b0, p2_col_q});

  // ---------------- accumulators ----------------
  logic signed [ACC_WIDTH-1:0] sums_q [NUM_SUMS];
  logic signed [ACC_WIDTH-1:0] sum_cur, sum_new;
  logic signed [SUM_W-1:0]     tot;
  logic                        acc_wr;

  assign sum_cur = sums_q[p3_tag_q.idx];
  assign tot     = SUM_W'(sum_cur) + SUM_W'(p3_inc_q);
  assign acc_wr  = adv && p3_vld_q && (p3_tag_q.kind == KIND_ADD);

  always_comb begin
    if (tot[SUM_W-1] != tot[SUM_W-2]) sum_new = tot[SUM_W-1] ? ACC_MIN : ACC_MAX;
    else                              sum_new = tot[ACC_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SUMS; i++) sums_q[i] <= '0;
    end else if (acc_wr) begin
      sums_q[p3_tag_q.idx] <= sum_new;
    end
  end

  // ---------------- readout stage 1: magnitude ----------------
  logic signed [EXT_W-1:0] s_ext;
  logic [EXT_W-1:0]        abs_v;
  logic [MAG_W-1:0]        mag;
  logic                    r1_vld_q;
  sh9_tag_t                r1_tag_q;
  logic                    r1_neg_q;
  logic [MAG_W-1:0]        r1_mag_q;

  assign s_ext = EXT_W'(sum_cur);
  assign abs_v = s_ext[EXT_W-1] ? EXT_W'(-s_ext) : EXT_W'(s_ext);

  always_comb begin
    // anything beyond the cap saturates the coefficient anyway
    if (abs_v > MAG_CAP) mag = MAG_CAP[MAG_W-1:0];
    else                 mag = abs_v[MAG_W-1:0];
  end

  // ---------------- readout stage 2: partial products ----------------
  logic [GAIN_W-1:0] gain;
  logic              r2_vld_q;
  sh9_tag_t          r2_tag_q;
  logic              r2_neg_q;
  logic [PL_W-1:0]   r2_pl_q;
  logic [MAG_W-1:0]  r2_ph_q;

  assign gain = band_gain(r1_tag_q.band);

  // ---------------- readout stage 3: round, saturate ----------------
  logic [EXT_W-1:0]  pl_rnd;
  logic [T_W-1:0]    t_sum;
  logic [Q_W-1:0]    q_mag;
  logic [COEF_W-1:0] coef;

  assign pl_rnd = EXT_W'(r2_pl_q) + RND_Q48;
  assign t_sum  = T_W'(r2_ph_q) + T_W'(pl_rnd[EXT_W-1:32]);
  assign q_mag  = t_sum[T_W-1:16];

  always_comb begin
    if (r2_neg_q) begin
      if (q_mag >= NEG_LIM) coef = NEG_LIM[COEF_W-1:0];
      else                  coef = COEF_W'(-q_mag[COEF_W-1:0]);
    end else begin
      if (q_mag > POS_LIM) coef = POS_LIM[COEF_W-1:0];
      else                 coef = q_mag[COEF_W-1:0];
    end
  end

  // ---------------- pipeline registers ----------------
  logic [COEF_W-1:0] out_coef_q;
  logic [BAND_W-1:0] out_band_q;
  logic [CH_W-1:0]   out_ch_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      r1_vld_q  <= 1'b0;
      r2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q  <= busy_q;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      r1_vld_q  <= p3_vld_q && (p3_tag_q.kind == KIND_READ);
      r2_vld_q  <= r1_vld_q;
      out_vld_q <= r2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_tag_q   <= tag_in;
      p1_basis_q <= basis;
      p1_w_q     <= item_q.weight;
      p1_col_q   <= col;

      p2_tag_q   <= p1_tag_q;
      p2_f_q     <= wrnd[WPROD_W-2:30];
      p2_col_q   <= p1_col_q;

      p3_tag_q   <= p2_tag_q;
      p3_inc_q   <= inc;

      r1_tag_q   <= p3_tag_q;
      r1_neg_q   <= s_ext[EXT_W-1];
      r1_mag_q   <= mag;

      r2_tag_q   <= r1_tag_q;
      r2_neg_q   <= r1_neg_q;
      r2_pl_q    <= PL_W'(r1_mag_q[31:0]) * PL_W'(gain);
      r2_ph_q    <= MAG_W'(r1_mag_q[MAG_W-1:32]) * MAG_W'(gain);

      out_coef_q <= coef;
      out_band_q <= r2_tag_q.band;
      out_ch_q   <= r2_tag_q.ch;
      out_last_q <= (r2_tag_q.idx == IDX_LAST);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.coefficient = $signed(out_coef_q);
  assign out_o.band        = out_band_q;
  assign out_o.channel     = out_ch_q;
  assign out_o.last        = out_last_q;

endmodule

// ===== design/sh9_checker.sv =====
// Port-level checks for the SH9 accumulator core, bound to the top level.
// Depends on sh9_pkg.
module sh9_checker import sh9_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_cmd_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BAND_W-1:0] out_band_i,
  input logic [CH_W-1:0]   out_channel_i,
  input logic              out_last_i,
  input logic [COEF_W-1:0] out_coefficient_i
);

  logic [BAND_W-1:0] exp_band_q;
  logic [CH_W-1:0]   exp_ch_q;
  logic [7:0]        pend_q;
  logic              rd_in, out_fire, last_fire;

  assign rd_in     = in_valid_i && in_ready_i && in_cmd_i;
  assign out_fire  = out_valid_i && out_ready_i;
  assign last_fire = out_fire && out_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_band_q <= BAND_ONE;
      exp_ch_q   <= CH_RED;
      pend_q     <= '0;
    end else begin
      if (out_fire) begin
        if (exp_ch_q == CH_BLUE) begin
          exp_ch_q   <= CH_RED;
          exp_band_q <= (exp_band_q == BAND_LAST) ? BAND_ONE : exp_band_q + 1'b1;
        end else begin
          exp_ch_q <= exp_ch_q + 1'b1;
        end
      end
      if (rd_in && !last_fire)      pend_q <= pend_q + 1'b1;
      else if (last_fire && !rd_in) pend_q <= pend_q - 1'b1;
    end
  end

  // Coefficients come band-major, red to blue
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_band_i == exp_band_q && out_channel_i == exp_ch_q))
    else $error("readout order broken");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (exp_band_q == BAND_LAST && exp_ch_q == CH_BLUE)))
    else $error("last flag misplaced");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("coefficient without a pending readout");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_coefficient_i))
    else $error("stalled coefficient not held");

endmodule

bind sh9_irradiance_accumulator_core sh9_checker u_sh9_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_cmd_i          (in_i.cmd),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_band_i        (out_o.band),
  .out_channel_i     (out_o.channel),
  .out_last_i        (out_o.last),
  .out_coefficient_i (out_o.coefficient)
);

// ===== tb/sv/tb_sh9_irradiance_accumulator_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sh9_irradiance_accumulator_core: directed table, then random requests.
// Depends on sh9_pkg and the sh9_in_if / sh9_out_if channel interfaces.
module tb_sh9_irradiance_accumulator_core import sh9_pkg::*;;

  localparam int unsigned ACC_W       = ACC_WIDTH_DEF;
  localparam int          RANDOM_REQS = 80;
  localparam int          HOLD_CYCLES = 400;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          DRAIN_CYCLES = 40;

  localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (ACC_W - 1)) - 66'sd1;
  localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;

  // Cosine-lobe gains per band, Q0.32
  localparam logic [31:0] LOBE_GAIN [9] = '{
    32'd341782638,
    32'd683565276, 32'd683565276, 32'd683565276,
    32'd1281684892, 32'd1281684892,
    32'd106807074,
    32'd1281684892,
    32'd320421223
  };

  typedef enum logic [1:0] {
    PIN_NONE,
    PIN_ALL,
    PIN_ONE
  } pin_e;

  typedef struct packed {
    sh9_item_t   item;
    logic [9:0]  reps;
    pin_e        pin;
    logic [3:0]  pin_band;
    logic [1:0]  pin_ch;
    logic [31:0] pin_coef;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] coef;
    logic [3:0]  band;
    logic [1:0]  channel;
    logic        last;
  } coef_exp_t;

  localparam int DIRECTED_ROWS = 16;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // readout straight after reset
    '{'{KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000},
      10'd1, PIN_ALL, BAND_ONE, CH_RED, 32'h0000_0000},
    // zero weight, then zero colour: both add nothing
    '{'{KIND_ADD, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h000000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_ADD, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000},
      10'd1, PIN_ALL, BAND_ONE, CH_RED, 32'h0000_0000},
    // axis directions
    '{'{KIND_ADD, 16'h7FFF, 16'h0000, 16'h0000, 16'h0100, 16'h0080, 16'hFFFF, 24'h800000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_ADD, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0100, 16'h0001, 24'hFFFFFF},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_ADD, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'hFFFF, 16'h0100, 24'h400000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    // non-unit direction, then half-way rounding ties with the smallest weight
    '{'{KIND_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0200, 16'h0200, 16'h0200, 24'h000001},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_ADD, 16'hC000, 16'h4000, 16'hC000, 16'h0001, 16'h0001, 16'h0001, 24'h000001},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    // alternating bit patterns
    '{'{KIND_ADD, 16'h5555, 16'hAAAA, 16'h5A5A, 16'hAAAA, 16'h5555, 16'h00FF, 24'hAAAAAA},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_ADD, 16'hAAAA, 16'h5555, 16'hA5A5, 16'h5555, 16'hAAAA, 16'hFF00, 24'h555555},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    // drive red xy up and red zx down with full-scale samples
    '{'{KIND_ADD, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 24'hFFFFFF},
      10'd8, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0},
    '{'{KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000},
      10'd1, PIN_NONE, BAND_ONE, CH_RED, 32'h0}
  };

  logic clk_i;
  logic rst_ni;

  sh9_in_if  sample_ch ();
  sh9_out_if coef_ch ();

  sh9_irradiance_accumulator_core #(
    .ACC_WIDTH(ACC_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (sample_ch),
    .out_o (coef_ch)
  );

  logic signed [63:0] proj_sum [NUM_SUMS];
  coef_exp_t          coef_q [$];

  int  idle_mode;
  int  req_cnt;
  int  add_cnt;
  int  read_cnt;
  int  coef_cnt;
  int  err_cnt;
  int  quiet_cnt;
  int  hold_left;
  logic hold_armed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Project one sample onto the nine bands and add it into the sums
  function automatic void accumulate_sample(input sh9_item_t it);
    longint xs, ys, zs, wt, f;
    longint term [9];
    longint colour [3];
    logic signed [65:0] s;
    int i, c;
    xs = longint'($signed(it.dir_x));
    ys = longint'($signed(it.dir_y));
    zs = longint'($signed(it.dir_z));
    wt = longint'(it.weight);
    colour[0] = longint'(it.red);
    colour[1] = longint'(it.green);
    colour[2] = longint'(it.blue);
    term[0] = 64'sd1 <<< 30;
    term[1] = ys * 32768;
    term[2] = zs * 32768;
    term[3] = xs * 32768;
    term[4] = xs * ys;
    term[5] = ys * zs;
    term[6] = 3 * zs * zs - (64'sd1 <<< 30);
    term[7] = zs * xs;
    term[8] = xs * xs - ys * ys;
    for (i = 0; i < 9; i++) begin
      f = (term[i] * wt + (64'sd1 <<< 29)) >>> 30;
      for (c = 0; c < 3; c++) begin
        s = 66'(proj_sum[i * 3 + c]) + 66'(f * colour[c]);
        if (s > ACC_HI) s = ACC_HI;
        if (s < ACC_LO) s = ACC_LO;
        proj_sum[i * 3 + c] = s[63:0];
      end
    end
  endfunction

  // Scale a sum by its lobe gain into saturating Q15.16, rounding half away from zero
  function automatic logic [31:0] lobe_scale(input logic signed [63:0] sum, input int band);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] q;
    mag = sum[63] ? 64'(-sum) : 64'(sum);
    if (mag > (64'd1 << 56)) mag = 64'd1 << 56;
    prod = {64'd0, mag} * {96'd0, LOBE_GAIN[band]} + (128'd1 << 47);
    q = prod >> 48;
    if (sum[63]) return (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic void queue_readout(input pin_e pin, input logic [3:0] pin_band,
                                        input logic [1:0] pin_ch, input logic [31:0] pin_coef);
    coef_exp_t e;
    int r;
    for (r = 0; r < NUM_SUMS; r++) begin
      e.band    = 4'(r / 3);
      e.channel = 2'(r % 3);
      e.last    = (r == NUM_SUMS - 1);
      e.coef    = lobe_scale(proj_sum[r], r / 3);
      if (pin == PIN_ALL || (pin == PIN_ONE && e.band == pin_band && e.channel == pin_ch))
        e.coef = pin_coef;
      coef_q.push_back(e);
    end
  endfunction

  // Offer one request and hold it until accepted
  task automatic offer(input sh9_item_t it, input pin_e pin, input logic [3:0] pin_band,
                       input logic [1:0] pin_ch, input logic [31:0] pin_coef);
    int idle_pct;
    idle_mode = (req_cnt / 12) % 4;
    idle_pct  = (idle_mode == 1) ? 54 : (idle_mode == 3) ? 36 : 0;
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.cmd    <= it.kind;
    sample_ch.dir_x  <= it.dir_x;
    sample_ch.dir_y  <= it.dir_y;
    sample_ch.dir_z  <= it.dir_z;
    sample_ch.red    <= it.red;
    sample_ch.green  <= it.green;
    sample_ch.blue   <= it.blue;
    sample_ch.weight <= it.weight;
    do @(posedge clk_i); while (!sample_ch.ready);
    req_cnt++;
    if (it.kind == KIND_ADD) begin
      accumulate_sample(it);
      add_cnt++;
    end else begin
      queue_readout(pin, pin_band, pin_ch, pin_coef);
      read_cnt++;
    end
  endtask

  initial begin : stimulus
    sh9_item_t   it;
    int          row, rep, n, sel, axis;
    logic [15:0] v;
    for (n = 0; n < NUM_SUMS; n++) proj_sum[n] = '0;
    req_cnt    = 0;
    add_cnt    = 0;
    read_cnt   = 0;
    idle_mode  = 0;
    hold_armed <= 1'b0;
    rst_ni     <= 1'b0;
    sample_ch.valid  <= 1'b0;
    sample_ch.cmd    <= KIND_ADD;
    sample_ch.dir_x  <= '0;
    sample_ch.dir_y  <= '0;
    sample_ch.dir_z  <= '0;
    sample_ch.red    <= '0;
    sample_ch.green  <= '0;
    sample_ch.blue   <= '0;
    sample_ch.weight <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < DIRECTED_ROWS; row++)
      for (rep = 0; rep < int'(DIRECTED[row].reps); rep++)
        offer(DIRECTED[row].item, DIRECTED[row].pin, DIRECTED[row].pin_band,
              DIRECTED[row].pin_ch, DIRECTED[row].pin_coef);

    for (n = 0; n < RANDOM_REQS; n++) begin
      // stall the sink for a long stretch while a run of readouts fills the block
      if (n == 30) hold_armed <= 1'b1;
      if (n == 60) begin
        sample_ch.valid <= 1'b0;
        do @(posedge clk_i); while (coef_q.size() != 0);
      end
      it.kind = ((n >= 30 && n < 36) || $urandom_range(7) == 0) ? KIND_READ : KIND_ADD;
      sel = $urandom_range(3);
      if (sel == 1) begin
        axis = $urandom_range(2);
        v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        it.dir_x = (axis == 0) ? v : 16'h0000;
        it.dir_y = (axis == 1) ? v : 16'h0000;
        it.dir_z = (axis == 2) ? v : 16'h0000;
      end else if (sel == 2) begin
        // at most unit length, spread over all octants
        it.dir_x = 16'($signed($urandom_range(37836)) - 18918);
        it.dir_y = 16'($signed($urandom_range(37836)) - 18918);
        it.dir_z = 16'($signed($urandom_range(37836)) - 18918);
      end else begin
        it.dir_x = 16'($urandom);
        it.dir_y = 16'($urandom);
        it.dir_z = 16'($urandom);
      end
      it.red    = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
      it.green  = 16'($urandom);
      it.blue   = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
      it.weight = ($urandom_range(3) == 0) ? 24'($urandom_range(255)) : 24'($urandom);
      offer(it, PIN_NONE, BAND_ONE, CH_RED, 32'h0);
    end

    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (coef_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests: %0d samples, %0d readouts, %0d coefficients compared.",
             req_cnt, add_cnt, read_cnt, coef_cnt);
    $display("Included zero sums, rounding ties, alternating bits and full-scale samples.");
    if (err_cnt == 0 && coef_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Sink side: random stalls per phase, plus one long hold-off
  initial begin : sink_drive
    int stall_pct;
    hold_left = HOLD_CYCLES;
    coef_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      stall_pct = (idle_mode == 2) ? 54 : (idle_mode == 3) ? 36 : 0;
      if (hold_armed && hold_left > 0) begin
        hold_left--;
        coef_ch.ready <= 1'b0;
      end else begin
        coef_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : coef_check
    coef_exp_t want;
    if (rst_ni) begin
      if (coef_ch.valid && coef_ch.ready) begin
        coef_cnt++;
        if (coef_q.size() == 0) begin
          $error("coefficient with nothing expected: band %0d channel %0d value %0d",
                 coef_ch.band, coef_ch.channel, coef_ch.coefficient);
          err_cnt++;
        end else begin
          want = coef_q.pop_front();
          if (coef_ch.coefficient !== want.coef) begin
            $error("coefficient: expected %0d, got %0d",
                   $signed(want.coef), coef_ch.coefficient);
            err_cnt++;
          end
          if (coef_ch.band !== want.band) begin
            $error("band: expected %0d, got %0d", want.band, coef_ch.band);
            err_cnt++;
          end
          if (coef_ch.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, coef_ch.channel);
            err_cnt++;
          end
          if (coef_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, coef_ch.last);
            err_cnt++;
          end
        end
      end
    end
    // advance the watchdog on cycles where neither channel completes a handshake
    if ((sample_ch.valid && sample_ch.ready) || (coef_ch.valid && coef_ch.ready))
      quiet_cnt = 0;
    else
      quiet_cnt++;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    err_cnt   = 0;
    coef_cnt  = 0;
    quiet_cnt = 0;
  end

endmodule
